// ===== hdl/assert_macros.svh =====
// assertion macros used by the steering core controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("%m failed");
// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("%m failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/phws_pkg.sv =====
// types and constants of the header steering core
`timescale 1ns / 1ps
package phws_pkg;

  // configuration register indexes
  localparam logic [1:0] RegWorkerCount  = 2'd0;
  localparam logic [1:0] RegExtraTagType = 2'd1;
  localparam logic [1:0] RegIpv6HashByte = 2'd2;

  // drop reasons
  localparam logic [3:0] RsnNone       = 4'd0;
  localparam logic [3:0] RsnShort      = 4'd1;
  localparam logic [3:0] RsnUnknown    = 4'd2;
  localparam logic [3:0] RsnLldp       = 4'd3;
  localparam logic [3:0] RsnBadVersion = 4'd4;
  localparam logic [3:0] RsnUnsupProto = 4'd5;
  localparam logic [3:0] RsnNoGreKey   = 4'd6;
  localparam logic [3:0] RsnInnerTag   = 4'd7;
  localparam logic [3:0] RsnDeepStack  = 4'd8;

  // ethertypes and protocols
  localparam logic [15:0] EthMpls  = 16'h8847;
  localparam logic [15:0] EthQinq  = 16'h88A8;
  localparam logic [15:0] EthIpv4  = 16'h0800;
  localparam logic [15:0] EthIpv6  = 16'h86DD;
  localparam logic [15:0] EthLldp  = 16'h88CC;
  localparam logic [15:0] EthVlan  = 16'h8100;
  localparam logic [7:0]  ProtoGre = 8'd47;
  localparam logic [7:0]  ProtoUdp = 8'd17;

  // remainder unit runs one hash bit per cycle
  localparam int DivSteps = 32;
  localparam int DivCntW  = $clog2(DivSteps);

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic div_step;  // one remainder step
    logic load_end;  // load the drop verdict of the closing item
    logic load_div;  // load the port from the remainder unit
  } phws_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;  // closing item carries a port verdict
  } phws_status_t;

endpackage

// ===== hdl/packet_header_worker_steering_core.sv =====
// Ethernet header steering core: one verdict per frame on the last byte.
// Takes one frame byte per cycle while parsing. A frame that is dropped
// gives its verdict in the cycle after its last byte is taken. A frame
// steered to a worker runs a bit-serial remainder unit (hash modulo worker
// count, plus the worker count for IPv6 frames) after its last byte, then
// waits in a load state until the output register is free; the verdict is
// registered from that state. No byte is taken in those states. The
// verdict waits in an output register, and no byte of the next frame is
// taken while that register is full and not being read. Configuration
// writes are always taken (cfg_ready_o is tied high); index 3 is ignored.
`timescale 1ns / 1ps
module packet_header_worker_steering_core #(
  parameter int MAX_LABELS      = 8,
  parameter int MIN_FRAME_BYTES = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  dest_port_o,
  output logic        dropped_o,
  output logic [3:0]  drop_reason_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import phws_pkg::*;

  phws_cmd_t    cmd;
  phws_status_t status;

  assign cfg_ready_o = 1'b1;

  // control
  phws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // parser and remainder datapath
  phws_dpath #(
    .MAX_LABELS      (MAX_LABELS),
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .dest_port_o   (dest_port_o),
    .dropped_o     (dropped_o),
    .drop_reason_o (drop_reason_o)
  );

endmodule

// ===== hdl/phws_ctrl.sv =====
// controller: handshakes, remainder sequencing and output slot
`timescale 1ns / 1ps
`include "assert_macros.svh"
module phws_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  phws_pkg::phws_status_t status_i,
  output phws_pkg::phws_cmd_t    cmd_o
);
  import phws_pkg::*;

  typedef enum logic [1:0] {S_PARSE, S_DIV, S_LOAD} state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 out_valid_q;
  logic                 slot_free;
  logic                 acc;

  // output slot is free when empty or being drained
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_PARSE) && slot_free;
  assign acc        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = acc;
    cmd_o.load_end = acc && frame_end_i && !status_i.need_div;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.load_div = (state_q == S_LOAD) && slot_free;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_PARSE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_end || cmd_o.load_div) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_PARSE: begin
          if (acc && frame_end_i && status_i.need_div) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (slot_free) begin
            state_q <= S_PARSE;
          end
        end
        default: state_q <= S_PARSE;
      endcase
    end
  end

  `ASSERT_CLK(a_div_blocks_input, (state_q != S_PARSE) |-> !in_ready_o)
  `ASSERT_CLK(a_div_start, (acc && frame_end_i && status_i.need_div) |=> (state_q == S_DIV && cnt_q == '0))
  `ASSERT_CLK(a_load_needs_slot, (cmd_o.load_end || cmd_o.load_div) |-> slot_free)
  `ASSERT_CLK(a_single_load, !(cmd_o.load_end && cmd_o.load_div))
  `ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == S_PARSE))

endmodule

// ===== hdl/phws_dpath.sv =====
// datapath: config registers, header parser, remainder unit, result register
`timescale 1ns / 1ps
module phws_dpath #(
  parameter int MAX_LABELS      = 8,
  parameter int MIN_FRAME_BYTES = 60
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   frame_end_i,
  input  phws_pkg::phws_cmd_t    cmd_i,
  output phws_pkg::phws_status_t status_o,
  output logic [7:0]             dest_port_o,
  output logic                   dropped_o,
  output logic [3:0]             drop_reason_o
);
  import phws_pkg::*;

  typedef enum logic [2:0] {
    PH_ETH, PH_QINQ, PH_MPLS, PH_MPLS_IP, PH_IP4, PH_IP6, PH_DONE
  } phase_e;

  // configuration
  logic [6:0]  wc_q;
  logic [15:0] xtag_q;
  logic [5:0]  v6byte_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] otype_q, otype_d;
  logic [4:0]  lbl_q, lbl_d;
  logic [7:0]  base_q, base_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  tflags_q, tflags_d;
  logic [31:0] hash_q, hash_d;
  logic [3:0]  rsn_q, rsn_d;
  logic [31:0] phash_q, phash_d;
  logic [6:0]  pwc_q, pwc_d;
  logic        pv6_q, pv6_d;

  // remainder unit
  logic [31:0] num_q;
  logic [6:0]  div_n_q;
  logic        div_v6_q;
  logic [6:0]  rem_q;
  logic [7:0]  trial;
  logic [7:0]  worker;

  // result register
  logic [7:0]  port_q;
  logic [3:0]  out_rsn_q;

  logic [15:0] rel;
  logic [15:0] gre_k;
  logic [31:0] shifted;
  logic        is_short;
  logic [3:0]  end_rsn;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q     <= 7'd1;
      xtag_q   <= EthVlan;
      v6byte_q <= 6'd23;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWorkerCount:  wc_q     <= cfg_data_i[6:0];
        RegExtraTagType: xtag_q   <= cfg_data_i;
        RegIpv6HashByte: v6byte_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign rel     = (pos_q >= {8'd0, base_q}) ? pos_q - {8'd0, base_q} : 16'd0;
  assign gre_k   = (tflags_q[7:6] != 2'b00) ? 16'd28 : 16'd24;
  assign shifted = {hash_q[23:0], data_byte_i};

  // per-byte header parsing
  always_comb begin
    phase_d  = phase_q;
    pos_d    = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
    otype_d  = otype_q;
    lbl_d    = lbl_q;
    base_d   = base_q;
    proto_d  = proto_q;
    tflags_d = tflags_q;
    hash_d   = hash_q;
    rsn_d    = rsn_q;
    phash_d  = phash_q;
    pwc_d    = pwc_q;
    pv6_d    = pv6_q;
    case (phase_q)
      PH_ETH: begin
        if (pos_q == 16'd12) begin
          otype_d = {data_byte_i, 8'h00};
        end else if (pos_q == 16'd13) begin
          otype_d = {otype_q[15:8], data_byte_i};
          if (otype_d == EthMpls) begin
            phase_d = PH_MPLS;
            base_d  = 8'd14;
            lbl_d   = 5'd0;
          end else if (otype_d == EthQinq) begin
            phase_d = PH_QINQ;
          end else if (otype_d == EthIpv4) begin
            phase_d = PH_IP4;
            base_d  = 8'd14;
          end else if (otype_d == EthIpv6) begin
            phase_d = PH_IP6;
            base_d  = 8'd14;
          end else if (otype_d == EthLldp) begin
            phase_d = PH_DONE;
            rsn_d   = RsnLldp;
          end else if (otype_d == xtag_q) begin
            phase_d = PH_QINQ;
          end else begin
            phase_d = PH_DONE;
            rsn_d   = RsnUnknown;
          end
        end
      end
      PH_QINQ: begin
        if (pos_q == 16'd16) begin
          hash_d = {24'd0, data_byte_i};
        end else if (pos_q == 16'd17) begin
          if ({hash_q[7:0], data_byte_i} != EthVlan) begin
            phase_d = PH_DONE;
            rsn_d   = RsnInnerTag;
          end
        end else if (pos_q == 16'd18) begin
          hash_d = {20'd0, data_byte_i[3:0], 8'd0};
        end else if (pos_q == 16'd19) begin
          hash_d  = hash_q | {24'd0, data_byte_i};
          phase_d = PH_DONE;
          rsn_d   = RsnNone;
          phash_d = hash_d;
          pwc_d   = wc_q;
          pv6_d   = 1'b0;
        end
      end
      PH_MPLS: begin
        if (rel == 16'd2) begin
          tflags_d = {7'd0, data_byte_i[0]};
        end else if (rel == 16'd3) begin
          lbl_d = lbl_q + 5'd1;
          if (tflags_q[0]) begin
            phase_d = PH_MPLS_IP;
            base_d  = pos_q[7:0] + 8'd1;
          end else if (lbl_d >= 5'(MAX_LABELS)) begin
            phase_d = PH_DONE;
            rsn_d   = RsnDeepStack;
          end else begin
            base_d = pos_q[7:0] + 8'd1;
          end
        end
      end
      PH_MPLS_IP: begin
        if (data_byte_i[7:4] == 4'd4) begin
          phase_d = PH_IP4;
        end else if (data_byte_i[7:4] == 4'd6) begin
          phase_d = PH_IP6;
          if (v6byte_q == 6'd0) begin
            phase_d = PH_DONE;
            rsn_d   = RsnNone;
            phash_d = {24'd0, data_byte_i};
            pwc_d   = wc_q;
            pv6_d   = 1'b1;
          end
        end else begin
          phase_d = PH_DONE;
          rsn_d   = RsnBadVersion;
        end
      end
      PH_IP4: begin
        if (rel == 16'd0) begin
          if (data_byte_i[7:4] != 4'd4) begin
            phase_d = PH_DONE;
            rsn_d   = RsnBadVersion;
          end
        end else if (rel == 16'd9) begin
          proto_d = data_byte_i;
          hash_d  = 32'd0;
          if (data_byte_i != ProtoGre && data_byte_i != ProtoUdp) begin
            phase_d = PH_DONE;
            rsn_d   = RsnUnsupProto;
          end
        end else if (proto_q == ProtoUdp) begin
          if (rel >= 16'd16 && rel <= 16'd19) begin
            hash_d = shifted;
            if (rel == 16'd19) begin
              phase_d = PH_DONE;
              rsn_d   = RsnNone;
              phash_d = shifted;
              pwc_d   = wc_q;
              pv6_d   = 1'b0;
            end
          end
        end else if (proto_q == ProtoGre) begin
          if (rel == 16'd20) begin
            tflags_d = data_byte_i;
            if (!data_byte_i[5]) begin
              phase_d = PH_DONE;
              rsn_d   = RsnNoGreKey;
            end
          end else if (rel >= gre_k && rel < gre_k + 16'd4) begin
            hash_d = shifted;
            if (rel == gre_k + 16'd3) begin
              phase_d = PH_DONE;
              rsn_d   = RsnNone;
              phash_d = {4'h0, shifted[27:0]};
              pwc_d   = wc_q;
              pv6_d   = 1'b0;
            end
          end
        end
      end
      PH_IP6: begin
        if (rel == 16'd0 && data_byte_i[7:4] != 4'd6) begin
          phase_d = PH_DONE;
          rsn_d   = RsnBadVersion;
        end else if (rel == {10'd0, v6byte_q}) begin
          phase_d = PH_DONE;
          rsn_d   = RsnNone;
          phash_d = {24'd0, data_byte_i};
          pwc_d   = wc_q;
          pv6_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // verdict of the closing item
  assign is_short = ({1'b0, pos_q} + 17'd1) < 17'(MIN_FRAME_BYTES);
  assign end_rsn  = (is_short || phase_d != PH_DONE) ? RsnShort : rsn_d;
  assign status_o.need_div = frame_end_i && (end_rsn == RsnNone);

  // parse state registers, cleared at the end of each frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_ETH;
      pos_q    <= '0;
      otype_q  <= '0;
      lbl_q    <= '0;
      base_q   <= '0;
      proto_q  <= '0;
      tflags_q <= '0;
      hash_q   <= '0;
      rsn_q    <= '0;
      phash_q  <= '0;
      pwc_q    <= '0;
      pv6_q    <= 1'b0;
    end else if (cmd_i.accept) begin
      if (frame_end_i) begin
        phase_q  <= PH_ETH;
        pos_q    <= '0;
        otype_q  <= '0;
        lbl_q    <= '0;
        base_q   <= '0;
        proto_q  <= '0;
        tflags_q <= '0;
        hash_q   <= '0;
        rsn_q    <= '0;
        phash_q  <= '0;
        pwc_q    <= '0;
        pv6_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        otype_q  <= otype_d;
        lbl_q    <= lbl_d;
        base_q   <= base_d;
        proto_q  <= proto_d;
        tflags_q <= tflags_d;
        hash_q   <= hash_d;
        rsn_q    <= rsn_d;
        phash_q  <= phash_d;
        pwc_q    <= pwc_d;
        pv6_q    <= pv6_d;
      end
    end
  end

  // restoring remainder, one hash bit per step
  assign trial  = {rem_q, num_q[31]};
  assign worker = ((div_n_q == 7'd0) ? 8'd0 : {1'b0, rem_q})
                + (div_v6_q ? {1'b0, div_n_q} : 8'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && frame_end_i) begin
      num_q    <= phash_d;
      div_n_q  <= pwc_d;
      div_v6_q <= pv6_d;
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[30:0], 1'b0};
      if (div_n_q != 7'd0 && trial >= {1'b0, div_n_q}) begin
        rem_q <= 7'(trial - {1'b0, div_n_q});
      end else begin
        rem_q <= trial[6:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_end) begin
      port_q    <= 8'd0;
      out_rsn_q <= end_rsn;
    end else if (cmd_i.load_div) begin
      port_q    <= worker;
      out_rsn_q <= RsnNone;
    end
  end

  assign dest_port_o   = port_q;
  assign drop_reason_o = out_rsn_q;
  assign dropped_o     = (out_rsn_q != RsnNone);

endmodule
